// ===== design/pkpt_pkg.sv =====
// Package: item types, opcodes, status codes and chain structs of the pinned-key peer table.
package pkpt_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int TABLE_SLOTS_MAX = 64;
  localparam int IDX_MAX_W       = $clog2(TABLE_SLOTS_MAX);
  localparam int CNT_MAX_W       = $clog2(TABLE_SLOTS_MAX + 1);
  localparam int ID_W            = 64;
  localparam int KEY_W           = 256;

  localparam logic [1:0] OP_UPSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_COUNT  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_KEY    = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_MISMATCH  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] peer_id;
    logic        key_present;
    logic [63:0] key_in_0;
    logic [63:0] key_in_1;
    logic [63:0] key_in_2;
    logic [63:0] key_in_3;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [4:0]  used_count;
    logic [63:0] key_out_0;
    logic [63:0] key_out_1;
    logic [63:0] key_out_2;
    logic [63:0] key_out_3;
  } out_item_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                 hit;
    logic [IDX_MAX_W-1:0] hit_idx;
    logic [KEY_W-1:0]     hit_key;
    logic                 free_hit;
    logic [IDX_MAX_W-1:0] free_idx;
    logic [CNT_MAX_W-1:0] count;
  } pkpt_carry_t;

  // write broadcast to all cells
  typedef struct packed {
    logic                 we;
    logic                 set;
    logic [IDX_MAX_W-1:0] idx;
    logic [ID_W-1:0]      peer_id;
    logic [KEY_W-1:0]     key;
  } pkpt_wr_t;

endpackage

// ===== design/pkpt_cell.sv =====
// One table slot: holds valid mark, peer id and pinned key, and advances the search token.
module pkpt_cell import pkpt_pkg::*; #(
  parameter int SLOT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ID_W-1:0]   probe_id,
  input  pkpt_carry_t       carry_in,
  input  pkpt_wr_t          wr,
  output pkpt_carry_t       carry_out
);

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(SLOT);

  logic              valid_r, valid_nxt;
  logic [ID_W-1:0]   id_r;
  logic [KEY_W-1:0]  key_r;
  pkpt_carry_t       carry_r, carry_nxt;
  logic              sel;

  assign sel = wr.we && (wr.idx == MY_IDX);

  always_comb begin
    valid_nxt = valid_r;
    if (sel) begin
      valid_nxt = wr.set;
    end
  end

  always_comb begin
    carry_nxt = carry_in;
    if (!carry_in.hit && valid_r && (id_r == probe_id)) begin
      carry_nxt.hit     = 1'b1;
      carry_nxt.hit_idx = MY_IDX;
      carry_nxt.hit_key = key_r;
    end
    if (!carry_in.free_hit && !valid_r) begin
      carry_nxt.free_hit = 1'b1;
      carry_nxt.free_idx = MY_IDX;
    end
    carry_nxt.count = carry_in.count + CNT_MAX_W'(valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      carry_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.set) begin
      id_r  <= wr.peer_id;
      key_r <= wr.key;
    end
  end

  assign carry_out = carry_r;

endmodule

// ===== design/pinned_key_peer_table_top.sv =====
// Top level of the pinned-key peer table: item register, search sequencer and cell chain.
//
//  channel   ports                     handshake
//  input     start, busy, in_item      taken when start high and busy low
//  result    out_valid, out_item       one-cycle strobe, no back-pressure
//
// Each item's search token walks the cell chain one slot per cycle; when it leaves the last
// cell the result is registered and the table written back in the same cycle.
// busy drops in the cycle the result is shown, so the next item may start then.
// Reset (rst_n low, synchronous) clears every valid mark and the sequencer.
// The result strobe cannot be stalled; each item yields exactly one result.
module pinned_key_peer_table_top import pkpt_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [CW-1:0] SCAN_LAST = CW'(TABLE_SLOTS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  in_item_t          item_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  logic              accept, finish;
  logic [KEY_W-1:0]  item_key;
  pkpt_carry_t       carry [0:TABLE_SLOTS];
  pkpt_carry_t       c;
  pkpt_wr_t          wr;

  logic [2:0]            res_status;
  logic [IDX_MAX_W-1:0]  res_idx;
  logic [CNT_MAX_W-1:0]  res_cnt;
  logic [KEY_W-1:0]      res_key;

  assign accept   = start && (state_r == S_IDLE);
  assign finish   = (state_r == S_SCAN) && (cnt_r == SCAN_LAST);
  assign item_key = {item_r.key_in_3, item_r.key_in_2, item_r.key_in_1, item_r.key_in_0};
  assign carry[0] = '0;
  assign c        = carry[TABLE_SLOTS];

  genvar g;
  generate
    for (g = 0; g < TABLE_SLOTS; g++) begin : g_cell
      pkpt_cell #(.SLOT(g)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .probe_id  (item_r.peer_id),
        .carry_in  (carry[g]),
        .wr        (wr),
        .carry_out (carry[g+1])
      );
    end
  endgenerate

  // result and write-back, evaluated when the token leaves the last cell
  always_comb begin
    res_status = ST_OK;
    res_idx    = '0;
    res_cnt    = c.count;
    res_key    = '0;
    wr         = '0;
    wr.peer_id = item_r.peer_id;
    wr.key     = item_key;
    case (item_r.opcode)
      OP_UPSERT: begin
        if (!item_r.key_present) begin
          res_status = ST_NO_KEY;
        end else if (c.hit) begin
          if (c.hit_key != item_key) begin
            res_status = ST_MISMATCH;
          end else begin
            res_idx = c.hit_idx;
          end
        end else if (c.free_hit) begin
          res_idx = c.free_idx;
          res_cnt = c.count + CNT_MAX_W'(1);
          wr.we   = finish;
          wr.set  = 1'b1;
          wr.idx  = c.free_idx;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_LOOKUP: begin
        if (c.hit) begin
          res_idx = c.hit_idx;
          res_key = c.hit_key;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_REMOVE: begin
        if (c.hit) begin
          res_idx = c.hit_idx;
          res_cnt = c.count - CNT_MAX_W'(1);
          wr.we   = finish;
          wr.set  = 1'b0;
          wr.idx  = c.hit_idx;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_COUNT: begin
        res_status = ST_OK;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (accept) begin
      state_nxt = S_SCAN;
      cnt_nxt   = '0;
    end else if (finish) begin
      state_nxt           = S_IDLE;
      out_valid_nxt       = 1'b1;
      out_nxt.status      = res_status;
      out_nxt.slot_index  = res_idx[3:0];
      out_nxt.used_count  = res_cnt[4:0];
      out_nxt.key_out_0   = res_key[63:0];
      out_nxt.key_out_1   = res_key[127:64];
      out_nxt.key_out_2   = res_key[191:128];
      out_nxt.key_out_3   = res_key[255:192];
    end else if (state_r == S_SCAN) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an item was taken");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> (res_cnt <= CNT_MAX_W'(TABLE_SLOTS)))
    else $error("used slot count beyond table size");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != ST_OK)) |->
      (out_item.slot_index == 4'd0 && out_item.key_out_0 == 64'd0))
    else $error("failed result carries slot or key data");

endmodule

// ===== tb/sv/pinned_key_peer_table_top_test.sv =====
// Self-checking testbench of the pinned-key peer table: directed rows, then random items.
`timescale 1ns / 100ps

module pinned_key_peer_table_top_test;
  import pkpt_pkg::*;

  localparam int TABLE_SLOTS    = TABLE_SLOTS_DEF;
  localparam int RANDOM_ITEMS   = 800;
  localparam int QUIET_TAIL     = 100;
  localparam int ID_POOL        = 24;
  localparam int ITEM_CYCLES    = TABLE_SLOTS + 2;
  localparam int TAIL_CYCLES    = 2 * ITEM_CYCLES;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SHOW_LIMIT     = 10;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // predictor copy of the table
  logic [TABLE_SLOTS-1:0] slot_used;
  logic [63:0]            slot_id  [TABLE_SLOTS];
  logic [255:0]           slot_key [TABLE_SLOTS];

  out_item_t pending_results[$];
  stim_row_t directed_rows[$];

  int failures;
  int items_sent;
  int results_seen;
  int stall_cycles;
  int status_seen[8];

  pinned_key_peer_table_top #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [255:0] rand256();
    return {rand64(), rand64(), rand64(), rand64()};
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, logic [63:0] id, logic kp,
                                         logic [255:0] key);
    in_item_t it;
    it.opcode      = op;
    it.peer_id     = id;
    it.key_present = kp;
    it.key_in_0    = key[63:0];
    it.key_in_1    = key[127:64];
    it.key_in_2    = key[191:128];
    it.key_in_3    = key[255:192];
    return it;
  endfunction

  function automatic out_item_t make_result(logic [2:0] st, logic [3:0] idx, logic [4:0] cnt,
                                            logic [255:0] key);
    out_item_t r;
    r.status     = st;
    r.slot_index = idx;
    r.used_count = cnt;
    {r.key_out_3, r.key_out_2, r.key_out_1, r.key_out_0} = key;
    return r;
  endfunction

  function automatic void add_row(in_item_t it, bit typed, out_item_t r);
    stim_row_t row;
    row.item   = it;
    row.typed  = typed;
    row.result = r;
    directed_rows.push_back(row);
  endfunction

  // applies one item to the predictor table and returns its result
  function automatic out_item_t pinned_table_step(in_item_t it);
    out_item_t    r;
    int           hit;
    int           vacant;
    logic [255:0] key;
    r      = '0;
    hit    = -1;
    vacant = -1;
    key    = {it.key_in_3, it.key_in_2, it.key_in_1, it.key_in_0};
    // walk downwards so the lowest slot wins
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_id[i] == it.peer_id) hit = i;
      if (!slot_used[i]) vacant = i;
    end
    r.status = ST_OK;
    case (it.opcode)
      OP_UPSERT: begin
        if (!it.key_present) begin
          r.status = ST_NO_KEY;
        end else begin
          if (hit >= 0) begin
            if (slot_key[hit] != key) r.status = ST_MISMATCH;
          end else if (vacant < 0) begin
            r.status = ST_FULL;
          end else begin
            hit = vacant;
          end
          if (r.status == ST_OK) begin
            slot_used[hit] = 1'b1;
            slot_id[hit]   = it.peer_id;
            slot_key[hit]  = key;
            r.slot_index   = 4'(hit);
          end
        end
      end
      OP_LOOKUP: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.slot_index = 4'(hit);
          {r.key_out_3, r.key_out_2, r.key_out_1, r.key_out_0} = slot_key[hit];
        end
      end
      OP_REMOVE: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          slot_used[hit] = 1'b0;
          r.slot_index   = 4'(hit);
        end
      end
      default: ;
    endcase
    r.used_count = 5'($countones(slot_used));
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 17);
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t typed_result, int gap);
    out_item_t pred;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    // predictor always runs so its table tracks the block
    pred = pinned_table_step(it);
    pending_results.push_back(typed ? typed_result : pred);
    items_sent++;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= SHOW_LIMIT)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= SHOW_LIMIT) $display("result with no item pending: %h", out_item);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        status_seen[want.status]++;
        check_field("status",     64'(want.status),     64'(out_item.status));
        check_field("slot_index", 64'(want.slot_index), 64'(out_item.slot_index));
        check_field("used_count", 64'(want.used_count), 64'(out_item.used_count));
        check_field("key_out_0",  want.key_out_0,       out_item.key_out_0);
        check_field("key_out_1",  want.key_out_1,       out_item.key_out_1);
        check_field("key_out_2",  want.key_out_2,       out_item.key_out_2);
        check_field("key_out_3",  want.key_out_3,       out_item.key_out_3);
      end
    end
  end

  // no item taken and no result for too long
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[pinned_key_peer_table_top] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [63:0]  pool_id  [ID_POOL];
    logic [255:0] pool_key [ID_POOL];
    logic [255:0] key_ones;
    logic [255:0] key_zero;
    logic [63:0]  id_ones;
    logic [63:0]  id;
    logic [255:0] key;
    logic [1:0]   op;
    logic         kp;
    int           p;
    int           sel;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    slot_used = '0;
    failures  = 0;
    key_ones  = '1;
    key_zero  = '0;
    id_ones   = '1;
    foreach (slot_id[i]) begin
      slot_id[i]  = '0;
      slot_key[i] = '0;
    end
    foreach (pool_id[i]) begin
      pool_id[i]  = rand64();
      pool_key[i] = rand256();
    end
    pool_id[0] = '0;
    pool_id[1] = id_ones;

    add_row(make_item(OP_COUNT, rand64(), 1'b1, rand256()), 1,
            make_result(ST_OK, 4'd0, 5'd0, key_zero));
    add_row(make_item(OP_LOOKUP, 64'd0, 1'b1, rand256()), 1,
            make_result(ST_NOT_FOUND, 4'd0, 5'd0, key_zero));
    add_row(make_item(OP_UPSERT, 64'd0, 1'b1, key_ones), 1,
            make_result(ST_OK, 4'd0, 5'd1, key_zero));
    add_row(make_item(OP_UPSERT, id_ones, 1'b1, key_zero), 1,
            make_result(ST_OK, 4'd1, 5'd2, key_zero));
    // missing key wins over a known identifier
    add_row(make_item(OP_UPSERT, id_ones, 1'b0, key_zero), 1,
            make_result(ST_NO_KEY, 4'd0, 5'd2, key_zero));
    add_row(make_item(OP_UPSERT, 64'd0, 1'b1, key_ones), 1,
            make_result(ST_OK, 4'd0, 5'd2, key_zero));
    add_row(make_item(OP_UPSERT, 64'd0, 1'b1, {1'b0, key_ones[254:0]}), 1,
            make_result(ST_MISMATCH, 4'd0, 5'd2, key_zero));
    add_row(make_item(OP_LOOKUP, 64'd0, 1'b0, rand256()), 1,
            make_result(ST_OK, 4'd0, 5'd2, key_ones));
    add_row(make_item(OP_LOOKUP, id_ones, 1'b1, key_ones), 1,
            make_result(ST_OK, 4'd1, 5'd2, key_zero));
    add_row(make_item(OP_REMOVE, 64'd0, 1'b1, rand256()), 1,
            make_result(ST_OK, 4'd0, 5'd1, key_zero));
    add_row(make_item(OP_REMOVE, 64'd0, 1'b0, rand256()), 1,
            make_result(ST_NOT_FOUND, 4'd0, 5'd1, key_zero));
    // fill the rest of the table, slot 0 first
    for (int i = 0; i < TABLE_SLOTS - 1; i++)
      add_row(make_item(OP_UPSERT, 64'd100 + 64'(i), 1'b1, rand256()), 0, '0);
    add_row(make_item(OP_UPSERT, 64'd7, 1'b1, rand256()), 1,
            make_result(ST_FULL, 4'd0, 5'(TABLE_SLOTS), key_zero));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result,
                pick_gap(1'b0));

    // mostly a small identifier pool so hits, mismatches and a full table all occur
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      p = $urandom_range(0, ID_POOL - 1);
      id = ($urandom_range(0, 15) == 0) ? rand64() : pool_id[p];
      if ($urandom_range(0, 15) == 0) pool_key[p] = rand256();
      sel = $urandom_range(0, 99);
      if (sel < 40)      op = OP_UPSERT;
      else if (sel < 65) op = OP_LOOKUP;
      else if (sel < 90) op = OP_REMOVE;
      else               op = OP_COUNT;
      kp  = (op == OP_UPSERT) ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
      key = (op == OP_UPSERT && $urandom_range(0, 7) != 0) ? pool_key[p] : rand256();
      send_item(make_item(op, id, kp, key), 0, '0, pick_gap(n >= RANDOM_ITEMS - QUIET_TAIL));
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d items (%0d directed), %0d results checked",
             items_sent, directed_rows.size(), results_seen);
    $display("status mix: ok %0d, no key %0d, not found %0d, mismatch %0d, full %0d",
             status_seen[ST_OK], status_seen[ST_NO_KEY], status_seen[ST_NOT_FOUND],
             status_seen[ST_MISMATCH], status_seen[ST_FULL]);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("[pinned_key_peer_table_top] OK");
    end else begin
      $display("%0d failures", failures);
      $display("[pinned_key_peer_table_top] ERROR");
    end
    $finish;
  end

endmodule
